// File: rtl/core/gh94_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gh94_pkg
// shared types, constants and helper functions of the hash engine
// ---------------------------------------------------------------------------
package gh94_pkg;

  localparam int NumSbox    = 8;
  localparam int CfgIdxW    = 3;
  localparam int PsiFirst   = 12;
  localparam int PsiLast    = 61;
  localparam int CntW       = 7;

  // which block the datapath is stepping
  typedef enum logic [1:0] {
    BLK_DATA  = 2'd0,
    BLK_ZERO  = 2'd1,
    BLK_LEN   = 2'd2,
    BLK_SUM   = 2'd3
  } blk_sel_t;

  typedef struct packed {
    logic     load_word;   // absorb one input word
    logic     blk_start;   // latch h and m, start key gen
    blk_sel_t blk_sel;
    logic     key_next;    // advance u,v for next key
    logic     enc_load;    // load cipher input half q
    logic     enc_round;   // one cipher round
    logic     enc_store;   // store cipher output half q
    logic     psi;         // one psi shift on s
    logic     mix_m;       // s ^= m then psi
    logic     mix_h;       // s ^= h
    logic     commit;      // h <= s, checksum update for data blocks
    logic     clear;       // back to reset state
    logic     pad;         // zero bytes at and above fill
  } gh94_cmd_t;

  typedef struct packed {
    logic       block_full;
    logic       fill_nz;
    logic       len_zero;
  } gh94_sts_t;

  function automatic logic [255:0] xform_a(input logic [255:0] w);
    return {w[63:0] ^ w[127:64], w[255:64]};
  endfunction

  function automatic logic [255:0] xform_p(input logic [255:0] w);
    logic [255:0] k;
    k = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 8; j++) begin
        k[8*(i+4*j) +: 8] = w[8*(8*i+j) +: 8];
      end
    end
    return k;
  endfunction

  function automatic logic [255:0] xform_psi(input logic [255:0] d);
    logic [15:0] f;
    f = d[15:0] ^ d[31:16] ^ d[47:32] ^ d[63:48] ^ d[207:192] ^ d[255:240];
    return {f, d[255:16]};
  endfunction

  // bytes 1,3,5,7,8,10,12,14,17,18,20,23,24,28,29,31 inverted
  localparam logic [255:0] C3Mask = {
    8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff,
    8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00,
    8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff,
    8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00};

endpackage

`default_nettype wire

// File: rtl/core/gh94_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gh94_ctrl
// sequencer: absorbs words, runs block steps and finalization, emits digest
// ---------------------------------------------------------------------------
module gh94_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_last_word,
  input  wire gh94_pkg::gh94_sts_t sts,
  output gh94_pkg::gh94_cmd_t    cmd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_word_index
);
  import gh94_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_START, S_KEY, S_LOAD, S_ROUND, S_STORE,
    S_PSI1, S_MIXM, S_MIXH, S_PSI2, S_COMMIT, S_OUT
  } state_t;

  state_t         state_r, state_nxt;
  logic [1:0]     q_r, q_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic           fin_r, fin_nxt;
  blk_sel_t       sel_r, sel_nxt;
  logic [1:0]     oidx_r, oidx_nxt;

  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    sel_nxt   = sel_r;
    oidx_nxt  = oidx_r;
    cmd       = '0;
    cmd.blk_sel = sel_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_word = 1'b1;
          fin_nxt = in_last_word;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // one block per word at most since fill < 32 and a word adds <= 8
        if (sts.block_full) begin
          sel_nxt = BLK_DATA;
          state_nxt = S_START;
        end else if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (sel_r == BLK_SUM) begin
          oidx_nxt = 2'd0;
          state_nxt = S_OUT;
        end else if (sel_r == BLK_LEN) begin
          sel_nxt = BLK_SUM;
          state_nxt = S_START;
        end else if (sts.fill_nz) begin
          cmd.pad = 1'b1;
          sel_nxt = BLK_DATA;
          state_nxt = S_START;
        end else if (sts.len_zero && sel_r != BLK_ZERO) begin
          sel_nxt = BLK_ZERO;
          state_nxt = S_START;
        end else begin
          sel_nxt = BLK_LEN;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.blk_start = 1'b1;
        q_nxt = 2'd0;
        state_nxt = S_LOAD;
      end
      S_KEY: begin
        cmd.key_next = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.enc_load = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.enc_round = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(31)) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.enc_store = 1'b1;
        q_nxt = q_r + 1'b1;
        cnt_nxt = '0;
        state_nxt = (q_r == 2'd3) ? S_PSI1 : S_KEY;
      end
      S_PSI1: begin
        cmd.psi = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(PsiFirst - 1)) state_nxt = S_MIXM;
      end
      S_MIXM: begin
        cmd.mix_m = 1'b1;
        state_nxt = S_MIXH;
      end
      S_MIXH: begin
        cmd.mix_h = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_PSI2;
      end
      S_PSI2: begin
        cmd.psi = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntW'(PsiLast - 1)) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_CHECK;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          oidx_nxt = oidx_r + 1'b1;
          if (oidx_r == 2'd3) begin
            cmd.clear = 1'b1;
            fin_nxt = 1'b0;
            sel_nxt = BLK_DATA;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_word_index = oidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      q_r     <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      sel_r   <= BLK_DATA;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      q_r     <= q_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      sel_r   <= sel_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gh94_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gh94_datapath
// block buffer, chain value, checksum, key generator, cipher and psi unit
// ---------------------------------------------------------------------------
module gh94_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [63:0]         in_message_word,
  input  wire logic [3:0]          in_byte_count,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [63:0]         cfg_data,
  input  wire gh94_pkg::gh94_cmd_t cmd,
  output gh94_pkg::gh94_sts_t      sts,
  input  wire logic [1:0]          word_index,
  output logic [63:0]              digest_word
);
  import gh94_pkg::*;

  logic [63:0]  sbox_r [NumSbox];
  logic [255:0] buf_r, h_r, sum_r, m_r, u_r, v_r, s_r, key_r;
  logic [255:0] blk_r;
  logic [63:0]  len_r;
  logic [5:0]   fill_r;
  logic [31:0]  n1_r, n2_r;
  logic [4:0]   rnd_r;
  logic [1:0]   q_r;
  logic         full_r;

  // byte insertion of one word, fill wraps inside the 32-byte buffer
  logic [3:0]   cnt_sat;
  logic [255:0] buf_nxt, blk_nxt;
  logic [5:0]   fill_nxt;
  always_comb begin
    cnt_sat  = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
    buf_nxt  = buf_r;
    blk_nxt  = buf_r;
    fill_nxt = fill_r;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < cnt_sat) begin
        buf_nxt[8*fill_nxt[4:0] +: 8] = in_message_word[8*i +: 8];
        // completed block keeps only the bytes up to its end
        if (!fill_nxt[5]) blk_nxt[8*fill_nxt[4:0] +: 8] = in_message_word[8*i +: 8];
        fill_nxt = fill_nxt + 6'd1;
      end
    end
  end

  // padded block: zero every byte at or above fill
  logic [255:0] pad_mask;
  always_comb begin
    for (int i = 0; i < 32; i++) pad_mask[8*i +: 8] = (6'(i) < fill_r) ? 8'hff : 8'h00;
  end

  logic [255:0] m_sel;
  always_comb begin
    case (cmd.blk_sel)
      BLK_DATA: m_sel = full_r ? blk_r : buf_r;
      BLK_ZERO: m_sel = '0;
      BLK_LEN:  m_sel = {192'd0, len_r[60:0], 3'd0};
      BLK_SUM:  m_sel = sum_r;
      default:  m_sel = '0;
    endcase
  end

  // key for round r: rounds 0..23 forward, 24..31 reversed
  logic [2:0]  kidx;
  logic [31:0] rk, rx, ry, rf;
  always_comb begin
    kidx = (rnd_r < 5'd24) ? rnd_r[2:0] : ~rnd_r[2:0];
    rk   = key_r[32*kidx +: 32];
    rx   = (rnd_r[0] ? n2_r : n1_r) + rk;
    for (int r = 0; r < 8; r++) ry[4*r +: 4] = sbox_r[r][4*rx[4*r +: 4] +: 4];
    rf   = {ry[20:0], ry[31:21]};
  end

  logic [255:0] ua, uq;
  always_comb begin
    ua = xform_a(u_r);
    uq = (q_r == 2'd2) ? (ua ^ C3Mask) : ua;
  end

  logic [255:0] sum_add;
  assign sum_add = sum_r + m_r;

  always_ff @(posedge clk) begin
    if (cfg_we) sbox_r[cfg_idx] <= cfg_data;
    if (!rst_n) begin
      for (int r = 0; r < NumSbox; r++) sbox_r[r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      h_r    <= '0;
      sum_r  <= '0;
      len_r  <= '0;
      fill_r <= '0;
    end else begin
      if (cmd.load_word) begin
        buf_r  <= buf_nxt;
        fill_r <= (fill_nxt >= 6'd32) ? fill_nxt - 6'd32 : fill_nxt;
        if (fill_nxt >= 6'd32) begin
          len_r <= len_r + 64'd32;
          blk_r <= blk_nxt;
        end
      end
      if (cmd.pad) begin
        buf_r  <= buf_r & pad_mask;
        len_r  <= len_r + 64'(fill_r);
        fill_r <= '0;
      end
      if (cmd.commit) begin
        h_r <= s_r;
        if (cmd.blk_sel == BLK_DATA) sum_r <= sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= '0;
      rnd_r <= '0;
      full_r <= 1'b0;
    end else begin
      if (cmd.load_word) full_r <= (fill_nxt >= 6'd32);
      if (cmd.blk_start) begin
        full_r <= 1'b0;
        q_r <= '0;
      end
      if (cmd.enc_load) rnd_r <= '0;
      if (cmd.enc_round) rnd_r <= rnd_r + 5'd1;
      if (cmd.enc_store) q_r <= q_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_start) begin
      m_r   <= m_sel;
      u_r   <= h_r;
      v_r   <= m_sel;
      key_r <= xform_p(h_r ^ m_sel);
    end
    if (cmd.key_next) begin
      u_r   <= uq;
      v_r   <= xform_a(xform_a(v_r));
      key_r <= xform_p(uq ^ xform_a(xform_a(v_r)));
    end
    if (cmd.enc_load) begin
      n1_r <= h_r[64*q_r +: 32];
      n2_r <= h_r[64*q_r + 32 +: 32];
    end
    if (cmd.enc_round) begin
      if (rnd_r[0]) n1_r <= n1_r ^ rf;
      else          n2_r <= n2_r ^ rf;
    end
    if (cmd.enc_store) s_r[64*q_r +: 64] <= {n1_r, n2_r};
    if (cmd.psi)   s_r <= xform_psi(s_r);
    if (cmd.mix_m) s_r <= xform_psi(s_r ^ m_r);
    if (cmd.mix_h) s_r <= s_r ^ h_r;
  end

  assign sts.block_full = full_r;
  assign sts.fill_nz    = (fill_r != '0);
  assign sts.len_zero   = (len_r == '0);
  assign digest_word    = h_r[64*word_index +: 64];

endmodule

`default_nettype wire

// File: rtl/core/gost_94_hash_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gost_94_hash_engine
// GOST R 34.11-94 hash over a stream of 64-bit message words
// ---------------------------------------------------------------------------
// A word is absorbed, then checked. Each completed 32-byte block runs the
// step function on one shared cipher round unit: 4 encryptions of 32 rounds
// plus key and load cycles, then 74 psi shifts; no word is taken meanwhile.
// The last word adds up to four more block steps (padded block, zero block
// for an empty message, length, checksum) before four digest words come out,
// index 0 first. S-box rows must be written through cfg only while idle;
// the block does not enforce this. The rows persist across messages.
module gost_94_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_message_word,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic [1:0]       out_word_index,
  output logic             out_last_result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import gh94_pkg::*;

  gh94_cmd_t cmd;
  gh94_sts_t sts;

  assign cfg_ready = 1'b1;

  gh94_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last_word,
    .sts, .cmd, .out_valid, .out_ready, .out_word_index
  );

  gh94_datapath u_dp (
    .clk, .rst_n, .in_message_word, .in_byte_count,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .cmd, .sts, .word_index(out_word_index), .digest_word(out_digest_word)
  );

  assign out_last_result = (out_word_index == 2'd3);

  a_in_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while digest pending");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_word_index != 2'd3 |=> out_valid)
    else $error("digest words interrupted");
  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> in_ready)
    else $error("not idle after digest");

endmodule

`default_nettype wire
